[rtl/uwf_pkg.sv]
// Package for the UART word-framing device: shared types and codes.
// No dependencies; used by the interfaces, the transmitter and the top level.
package uwf_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_READ   = 2'd2,
    KIND_SUPPLY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_CHAR     = 2'd1,
    EV_STR_END  = 2'd2,
    EV_INT_DONE = 2'd3
  } tx_event_e;

  localparam logic [1:0] ADDR_TX     = 2'd0;
  localparam logic [1:0] ADDR_RX     = 2'd1;
  localparam logic [1:0] ADDR_STATUS = 2'd2;

  localparam logic [1:0] CFG_WAIT_TICKS   = 2'd0;
  localparam logic [1:0] CFG_STRING_CODE  = 2'd1;
  localparam logic [1:0] CFG_INTEGER_CODE = 2'd2;

  localparam logic [7:0] WAIT_TICKS_RST   = 8'd0;
  localparam logic [7:0] STRING_CODE_RST  = 8'd0;
  localparam logic [7:0] INTEGER_CODE_RST = 8'd4;
  localparam logic [1:0] STATUS_RST       = 2'b11;

  typedef struct packed {
    logic [7:0] wait_ticks;
    logic [7:0] string_code;
    logic [7:0] integer_code;
  } cfg_t;

  typedef struct packed {
    logic        set_ready;
    tx_event_e   ev;
    logic [31:0] value;
    logic        error;
  } tx_res_t;

endpackage

[rtl/uwf_if.sv]
// Valid/ready channel interfaces for the request and result transactions.
// Depends on uwf_pkg.
interface uwf_in_if;
  logic              valid;
  logic              ready;
  uwf_pkg::kind_e    kind;
  logic [1:0]        reg_addr;
  logic [7:0]        write_byte;
  logic [31:0]       supplied_word;

  modport source (output valid, kind, reg_addr, write_byte, supplied_word, input ready);
  modport sink   (input valid, kind, reg_addr, write_byte, supplied_word, output ready);
endinterface

interface uwf_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          read_byte;
  logic [1:0]          status_bits;
  uwf_pkg::tx_event_e  tx_event;
  logic [31:0]         tx_value;
  logic                type_error;
  logic                word_wanted;

  modport source (output valid, read_byte, status_bits, tx_event, tx_value, type_error,
                  word_wanted, input ready);
  modport sink   (input valid, read_byte, status_bits, tx_event, tx_value, type_error,
                  word_wanted, output ready);
endinterface

[rtl/uwf_tx.sv]
// Transmitter: header decode, string/integer framing and completion delay.
// Depends on uwf_pkg. State advances only on a tick transaction.
module uwf_tx #(
  parameter int WORD_BYTES = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tick_i,
  input  logic             tx_ready_i,
  input  logic [7:0]       tx_data_i,
  input  uwf_pkg::cfg_t    cfg_i,
  output uwf_pkg::tx_res_t res_o
);

  localparam int BLW = ($clog2(WORD_BYTES + 1) > 3) ? $clog2(WORD_BYTES + 1) : 3;
  localparam logic [BLW-1:0] BL_FULL = BLW'(WORD_BYTES);

  logic           busy_q, busy_d;
  logic [7:0]     cd_q, cd_d;
  logic           hdr_q, hdr_d;
  logic           int_q, int_d;
  logic [BLW-1:0] bl_q, bl_d;
  logic [31:0]    asm_q, asm_d;

  always_comb begin
    logic done;
    busy_d = busy_q;
    cd_d   = cd_q;
    hdr_d  = hdr_q;
    int_d  = int_q;
    bl_d   = bl_q;
    asm_d  = asm_q;
    done   = 1'b0;
    res_o  = '{set_ready: 1'b0, ev: uwf_pkg::EV_NONE, value: 32'd0, error: 1'b0};

    if (busy_q) begin
      cd_d = (cd_q != 8'd0) ? cd_q - 8'd1 : 8'd0;
      done = (cd_d == 8'd0);
    end else if (!tx_ready_i) begin
      if (!hdr_q) begin
        if (tx_data_i == cfg_i.string_code) begin
          int_d = 1'b0;
          done  = (cfg_i.wait_ticks == 8'd0);
        end else if (tx_data_i == cfg_i.integer_code) begin
          int_d = 1'b1;
          bl_d  = BL_FULL;
          asm_d = 32'd0;
          done  = (cfg_i.wait_ticks == 8'd0);
        end else begin
          res_o.error     = 1'b1;
          res_o.set_ready = 1'b1;
        end
      end else begin
        asm_d = int_q ? {asm_q[23:0], tx_data_i} : {24'd0, tx_data_i};
        done  = (cfg_i.wait_ticks == 8'd0);
      end
      if (!res_o.error && cfg_i.wait_ticks != 8'd0) begin
        busy_d = 1'b1;
        cd_d   = cfg_i.wait_ticks;
      end
    end

    if (done) begin
      busy_d          = 1'b0;
      res_o.set_ready = 1'b1;
      if (!hdr_d) begin
        hdr_d = 1'b1;
      end else if (int_d) begin
        if (bl_d != '0) bl_d = bl_d - BLW'(1);
        if (bl_d == '0) begin
          res_o.ev    = uwf_pkg::EV_INT_DONE;
          res_o.value = asm_d;
          hdr_d       = 1'b0;
        end
      end else if (asm_d[7:0] == 8'd0) begin
        res_o.ev = uwf_pkg::EV_STR_END;
        hdr_d    = 1'b0;
      end else begin
        res_o.ev    = uwf_pkg::EV_CHAR;
        res_o.value = {24'd0, asm_d[7:0]};
      end
    end

    if (!tick_i) begin
      res_o = '{set_ready: 1'b0, ev: uwf_pkg::EV_NONE, value: 32'd0, error: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cd_q   <= 8'd0;
      hdr_q  <= 1'b0;
      int_q  <= 1'b0;
      bl_q   <= '0;
      asm_q  <= 32'd0;
    end else if (tick_i) begin
      busy_q <= busy_d;
      cd_q   <= cd_d;
      hdr_q  <= hdr_d;
      int_q  <= int_d;
      bl_q   <= bl_d;
      asm_q  <= asm_d;
    end
  end

endmodule

[rtl/uart_word_framing_device_core.sv]
// Top level of the UART word-framing device: register file, receiver, result register.
// Depends on uwf_pkg, uwf_if (uwf_in_if, uwf_out_if) and uwf_tx.
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    kind, reg_addr, write_byte, supplied_word
//  out_o    out  valid/ready    read_byte, status_bits, tx_event, tx_value, type_error,
//                               word_wanted
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle while in_i.ready is high; each result appears in the
// cycle after its request. in_i.ready is high whenever the result register is empty
// or being drained, so the result register is the only stage between the two sides.
// Reset is asynchronous, active low; no clearing pass is needed.
module uart_word_framing_device_core #(
  parameter int WORD_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  uwf_in_if.sink      in_i,
  uwf_out_if.source   out_o
);

  localparam int BLW = ($clog2(WORD_BYTES + 1) > 3) ? $clog2(WORD_BYTES + 1) : 3;
  localparam logic [BLW-1:0] BL_FULL = BLW'(WORD_BYTES);

  uwf_pkg::cfg_t    cfg_q;
  uwf_pkg::tx_res_t tx_res;

  logic [7:0]     tx_data_q, tx_data_d;
  logic [7:0]     rx_data_q, rx_data_d;
  logic [1:0]     status_q, status_d;
  logic           rx_busy_q, rx_busy_d;
  logic [7:0]     rx_cd_q, rx_cd_d;
  logic [BLW-1:0] rx_bl_q, rx_bl_d;
  logic [31:0]    rx_word_q, rx_word_d;
  logic           rx_hold_q, rx_hold_d;
  logic [7:0]     rx_pend_q, rx_pend_d;
  logic [7:0]     rbyte;

  logic           out_valid_q;
  logic [7:0]     o_rbyte_q;
  logic [1:0]     o_status_q;
  uwf_pkg::tx_event_e o_ev_q;
  logic [31:0]    o_value_q;
  logic           o_err_q;
  logic           o_want_q;

  logic accept, tick;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign tick       = accept && (in_i.kind == uwf_pkg::KIND_TICK);

  uwf_tx #(.WORD_BYTES(WORD_BYTES)) u_tx (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .tx_ready_i (status_q[0]),
    .tx_data_i  (tx_data_q),
    .cfg_i      (cfg_q),
    .res_o      (tx_res)
  );

  always_comb begin
    logic           rx_done;
    logic [BLW-1:0] idx;
    tx_data_d = tx_data_q;
    rx_data_d = rx_data_q;
    status_d  = status_q;
    rx_busy_d = rx_busy_q;
    rx_cd_d   = rx_cd_q;
    rx_bl_d   = rx_bl_q;
    rx_word_d = rx_word_q;
    rx_hold_d = rx_hold_q;
    rx_pend_d = rx_pend_q;
    rbyte     = 8'd0;
    rx_done   = 1'b0;
    idx       = '0;

    unique case (in_i.kind)
      uwf_pkg::KIND_TICK: begin
        if (tx_res.set_ready) status_d[0] = 1'b1;
        if (rx_busy_q) begin
          rx_cd_d = (rx_cd_q != 8'd0) ? rx_cd_q - 8'd1 : 8'd0;
          rx_done = (rx_cd_d == 8'd0);
        end else if (!status_q[1] && rx_hold_q) begin
          rx_bl_d = (rx_bl_q == '0) ? BL_FULL : rx_bl_q;
          idx     = rx_bl_d - BLW'(1);
          rx_pend_d = (idx < BLW'(4)) ? rx_word_q[{idx[1:0], 3'b000} +: 8] : 8'd0;
          rx_bl_d = idx;
          if (idx == '0) rx_hold_d = 1'b0;
          if (cfg_q.wait_ticks == 8'd0) begin
            rx_done = 1'b1;
          end else begin
            rx_busy_d = 1'b1;
            rx_cd_d   = cfg_q.wait_ticks;
          end
        end
        if (rx_done) begin
          rx_busy_d   = 1'b0;
          rx_data_d   = rx_pend_d;
          status_d[1] = 1'b1;
        end
      end
      uwf_pkg::KIND_WRITE: begin
        unique case (in_i.reg_addr)
          uwf_pkg::ADDR_TX:     tx_data_d = in_i.write_byte;
          uwf_pkg::ADDR_RX:     rx_data_d = in_i.write_byte;
          uwf_pkg::ADDR_STATUS: status_d  = in_i.write_byte[1:0];
          default: ;
        endcase
      end
      uwf_pkg::KIND_READ: begin
        unique case (in_i.reg_addr)
          uwf_pkg::ADDR_TX:     rbyte = tx_data_q;
          uwf_pkg::ADDR_RX:     rbyte = rx_data_q;
          uwf_pkg::ADDR_STATUS: rbyte = {6'd0, status_q};
          default:              rbyte = 8'd0;
        endcase
      end
      uwf_pkg::KIND_SUPPLY: begin
        if (!rx_hold_q) begin
          rx_word_d = in_i.supplied_word;
          rx_hold_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{wait_ticks:   uwf_pkg::WAIT_TICKS_RST,
                 string_code:  uwf_pkg::STRING_CODE_RST,
                 integer_code: uwf_pkg::INTEGER_CODE_RST};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        uwf_pkg::CFG_WAIT_TICKS:   cfg_q.wait_ticks   <= cfg_wdata_i;
        uwf_pkg::CFG_STRING_CODE:  cfg_q.string_code  <= cfg_wdata_i;
        uwf_pkg::CFG_INTEGER_CODE: cfg_q.integer_code <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_data_q <= 8'd0;
      rx_data_q <= 8'd0;
      status_q  <= uwf_pkg::STATUS_RST;
      rx_busy_q <= 1'b0;
      rx_cd_q   <= 8'd0;
      rx_bl_q   <= '0;
      rx_word_q <= 32'd0;
      rx_hold_q <= 1'b0;
      rx_pend_q <= 8'd0;
    end else if (accept) begin
      tx_data_q <= tx_data_d;
      rx_data_q <= rx_data_d;
      status_q  <= status_d;
      rx_busy_q <= rx_busy_d;
      rx_cd_q   <= rx_cd_d;
      rx_bl_q   <= rx_bl_d;
      rx_word_q <= rx_word_d;
      rx_hold_q <= rx_hold_d;
      rx_pend_q <= rx_pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      o_rbyte_q  <= rbyte;
      o_status_q <= status_d;
      o_ev_q     <= tx_res.ev;
      o_value_q  <= tx_res.value;
      o_err_q    <= tx_res.error;
      o_want_q   <= !rx_hold_d && !rx_busy_d && !status_d[1];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_byte   = o_rbyte_q;
  assign out_o.status_bits = o_status_q;
  assign out_o.tx_event    = o_ev_q;
  assign out_o.tx_value    = o_value_q;
  assign out_o.type_error  = o_err_q;
  assign out_o.word_wanted = o_want_q;

endmodule

[rtl/uwf_checker.sv]
// Port-level checks for the UART word-framing device, bound to the top level.
// Depends on uwf_pkg and uart_word_framing_device_core.
module uwf_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status_bits,
  input logic [1:0]  tx_event,
  input logic [31:0] tx_value,
  input logic        type_error,
  input logic        word_wanted
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(tx_value) && $stable(status_bits))
    else $error("result changed while stalled");

  a_err_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && type_error |-> status_bits[0] && tx_event == uwf_pkg::EV_NONE)
    else $error("header error without transmit ready");

  a_event_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && tx_event != uwf_pkg::EV_NONE |-> status_bits[0])
    else $error("transmit event without transmit ready");

  a_str_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (tx_event == uwf_pkg::EV_STR_END || tx_event == uwf_pkg::EV_NONE)
    |-> tx_value == 32'd0)
    else $error("nonzero value without value event");

  a_want: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && word_wanted |-> !status_bits[1])
    else $error("word wanted while receive ready");

endmodule

bind uart_word_framing_device_core uwf_port_checker u_uwf_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .status_bits (out_o.status_bits),
  .tx_event    (out_o.tx_event),
  .tx_value    (out_o.tx_value),
  .type_error  (out_o.type_error),
  .word_wanted (out_o.word_wanted)
);

[tb/uwf_checker.sv]
`timescale 1ns / 1ps
// Result checker for uart_word_framing_device_core: follows configuration writes, predicts
// each result transaction from the accepted requests and compares it field by field.
// Depends on uwf_pkg and the uwf_in_if / uwf_out_if interfaces.
module uwf_checker #(
  parameter int WORD_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  uwf_in_if          req_mon,
  uwf_out_if         res_mon,
  output int         fail_count_o,
  output int         pending_o
);

  typedef struct packed {
    logic [7:0]          read_byte;
    logic [1:0]          status_bits;
    uwf_pkg::tx_event_e  tx_event;
    logic [31:0]         tx_value;
    logic                type_error;
    logic                word_wanted;
  } uart_result_t;

  uart_result_t uart_results_due[$];
  int           mismatches = 0;

  logic [7:0]  cfg_wait, cfg_str_code, cfg_int_code;

  logic [7:0]  tx_data, rx_data;
  logic [1:0]  status;
  logic        tx_busy, tx_header, tx_integer;
  logic [7:0]  tx_count;
  logic [3:0]  tx_left;
  logic [31:0] tx_word;
  logic        rx_busy, rx_held;
  logic [7:0]  rx_count, rx_next;
  logic [3:0]  rx_left;
  logic [31:0] rx_word;

  uwf_pkg::tx_event_e ev_kind;
  logic [31:0]        ev_value;
  logic               ev_error;

  function automatic void reset_uart_model();
    cfg_wait     = uwf_pkg::WAIT_TICKS_RST;
    cfg_str_code = uwf_pkg::STRING_CODE_RST;
    cfg_int_code = uwf_pkg::INTEGER_CODE_RST;
    tx_data      = '0;
    rx_data      = '0;
    status       = uwf_pkg::STATUS_RST;
    tx_busy      = 1'b0;
    tx_header    = 1'b0;
    tx_integer   = 1'b0;
    tx_count     = '0;
    tx_left      = '0;
    tx_word      = '0;
    rx_busy      = 1'b0;
    rx_held      = 1'b0;
    rx_count     = '0;
    rx_next      = '0;
    rx_left      = '0;
    rx_word      = '0;
  endfunction

  function automatic void tx_finish();
    tx_busy = 1'b0;
    if (!tx_header) begin
      tx_header = 1'b1;
    end else if (tx_integer) begin
      if (tx_left != 0) tx_left--;
      if (tx_left == 0) begin
        ev_kind   = uwf_pkg::EV_INT_DONE;
        ev_value  = tx_word;
        tx_header = 1'b0;
      end
    end else if (tx_word[7:0] == 8'h00) begin
      ev_kind   = uwf_pkg::EV_STR_END;
      ev_value  = '0;
      tx_header = 1'b0;
    end else begin
      ev_kind  = uwf_pkg::EV_CHAR;
      ev_value = {24'd0, tx_word[7:0]};
    end
    status[0] = 1'b1;
  endfunction

  function automatic void tx_service();
    if (tx_busy) begin
      if (tx_count != 0) tx_count--;
      if (tx_count == 0) tx_finish();
      return;
    end
    if (status[0]) return;
    if (!tx_header) begin
      if (tx_data == cfg_str_code) begin
        tx_integer = 1'b0;
      end else if (tx_data == cfg_int_code) begin
        tx_integer = 1'b1;
        tx_left    = 4'(WORD_BYTES);
        tx_word    = '0;
      end else begin
        ev_error  = 1'b1;
        status[0] = 1'b1;
        return;
      end
    end else if (tx_integer) begin
      tx_word = {tx_word[23:0], tx_data};
    end else begin
      tx_word = {24'd0, tx_data};
    end
    if (cfg_wait == 0) begin
      tx_finish();
    end else begin
      tx_busy  = 1'b1;
      tx_count = cfg_wait;
    end
  endfunction

  function automatic void rx_finish();
    rx_busy   = 1'b0;
    rx_data   = rx_next;
    status[1] = 1'b1;
  endfunction

  function automatic void rx_service();
    int shift;
    if (rx_busy) begin
      if (rx_count != 0) rx_count--;
      if (rx_count == 0) rx_finish();
      return;
    end
    if (status[1] || !rx_held) return;
    if (rx_left == 0) rx_left = 4'(WORD_BYTES);
    shift   = (int'(rx_left) - 1) * 8;
    rx_next = (shift < 32) ? 8'(rx_word >> shift) : 8'h00;
    rx_left--;
    if (rx_left == 0) rx_held = 1'b0;
    if (cfg_wait == 0) begin
      rx_finish();
    end else begin
      rx_busy  = 1'b1;
      rx_count = cfg_wait;
    end
  endfunction

  function automatic uart_result_t predict_uart_step(input uwf_pkg::kind_e kind,
                                                     input logic [1:0] addr,
                                                     input logic [7:0] wbyte,
                                                     input logic [31:0] word);
    uart_result_t res;
    res      = '0;
    ev_kind  = uwf_pkg::EV_NONE;
    ev_value = '0;
    ev_error = 1'b0;
    case (kind)
      uwf_pkg::KIND_TICK: begin
        tx_service();
        rx_service();
      end
      uwf_pkg::KIND_WRITE: begin
        case (addr)
          uwf_pkg::ADDR_TX:     tx_data = wbyte;
          uwf_pkg::ADDR_RX:     rx_data = wbyte;
          uwf_pkg::ADDR_STATUS: status  = wbyte[1:0];
          default: ;
        endcase
      end
      uwf_pkg::KIND_READ: begin
        case (addr)
          uwf_pkg::ADDR_TX:     res.read_byte = tx_data;
          uwf_pkg::ADDR_RX:     res.read_byte = rx_data;
          uwf_pkg::ADDR_STATUS: res.read_byte = {6'd0, status};
          default: ;
        endcase
      end
      default: begin
        if (!rx_held) begin
          rx_word = word;
          rx_held = 1'b1;
        end
      end
    endcase
    res.status_bits = status;
    res.tx_event    = ev_kind;
    res.tx_value    = ev_value;
    res.type_error  = ev_error;
    res.word_wanted = !rx_held && !rx_busy && !status[1];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 200)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    uart_result_t got, want;
    if (!rst_ni) begin
      reset_uart_model();
      uart_results_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          uwf_pkg::CFG_WAIT_TICKS:   cfg_wait     = cfg_wdata_i;
          uwf_pkg::CFG_STRING_CODE:  cfg_str_code = cfg_wdata_i;
          uwf_pkg::CFG_INTEGER_CODE: cfg_int_code = cfg_wdata_i;
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        uart_results_due.push_back(predict_uart_step(req_mon.kind, req_mon.reg_addr,
                                                     req_mon.write_byte, req_mon.supplied_word));
      if (res_mon.valid && res_mon.ready) begin
        got.read_byte   = res_mon.read_byte;
        got.status_bits = res_mon.status_bits;
        got.tx_event    = res_mon.tx_event;
        got.tx_value    = res_mon.tx_value;
        got.type_error  = res_mon.type_error;
        got.word_wanted = res_mon.word_wanted;
        if (uart_results_due.size() == 0) begin
          report_mismatch("result transaction with none outstanding", got.tx_value, '0);
        end else begin
          want = uart_results_due.pop_front();
          if (got.read_byte != want.read_byte)
            report_mismatch("read_byte", got.read_byte, want.read_byte);
          if (got.status_bits != want.status_bits)
            report_mismatch("status_bits", got.status_bits, want.status_bits);
          if (got.tx_event != want.tx_event)
            report_mismatch("tx_event", got.tx_event, want.tx_event);
          if (got.tx_value != want.tx_value)
            report_mismatch("tx_value", got.tx_value, want.tx_value);
          if (got.type_error != want.type_error)
            report_mismatch("type_error", got.type_error, want.type_error);
          if (got.word_wanted != want.word_wanted)
            report_mismatch("word_wanted", got.word_wanted, want.word_wanted);
        end
      end
    end
    pending_o    <= uart_results_due.size();
    fail_count_o <= mismatches;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Top of the testbench for uart_word_framing_device_core: clock, reset, configuration
// phases and request traffic with random idling on both channels; verdict from uwf_checker.
// Depends on uwf_pkg, uwf_in_if / uwf_out_if, uwf_checker and the RTL.
module testbench;

  localparam int WORD_BYTES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 6;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [7:0] cfg_wdata;
  int         mismatch_total;
  int         results_due;

  int   wait_cur, str_cur, int_cur;
  int   item_count = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  logic hold_req = 1'b0;

  // the long-wait phase runs whole messages of about 260 transactions per byte
  int phase_wait[PHASES]   = '{0, 1, 3, 255, 2, 0};
  int phase_str[PHASES]    = '{0, 255, 16, 32, 0, 90};
  int phase_int[PHASES]    = '{4, 0, 16, 48, 255, 165};
  int phase_budget[PHASES] = '{220, 220, 220, 300, 200, 180};

  uwf_in_if  req_ch ();
  uwf_out_if res_ch ();

  uart_word_framing_device_core #(.WORD_BYTES(WORD_BYTES)) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (req_ch),
    .out_o       (res_ch)
  );

  uwf_checker #(.WORD_BYTES(WORD_BYTES)) chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .req_mon      (req_ch),
    .res_mon      (res_ch),
    .fail_count_o (mismatch_total),
    .pending_o    (results_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic push_req(input uwf_pkg::kind_e k, input logic [1:0] a, input logic [7:0] b,
                          input logic [31:0] w);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= k;
    req_ch.reg_addr      <= a;
    req_ch.write_byte    <= b;
    req_ch.supplied_word <= w;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    item_count++;
  endtask

  task automatic tick_n(input int n);
    repeat (n) push_req(uwf_pkg::KIND_TICK, 2'($urandom), 8'($urandom), $urandom);
  endtask

  // write the byte, clear transmit ready, then tick, mostly long enough for the take to complete
  task automatic tx_byte(input logic [7:0] b);
    logic [7:0] st;
    int         n;
    st    = 8'($urandom);
    st[0] = 1'b0;
    if ($urandom_range(0, 3) != 0) st[1] = 1'b1;
    push_req(uwf_pkg::KIND_WRITE, uwf_pkg::ADDR_TX, b, $urandom);
    push_req(uwf_pkg::KIND_WRITE, uwf_pkg::ADDR_STATUS, st, $urandom);
    n = wait_cur + 1;
    if ($urandom_range(0, 7) == 0) n = $urandom_range(1, wait_cur + 2);
    tick_n(n);
  endtask

  task automatic rx_byte();
    logic [7:0] st;
    logic [1:0] a;
    st    = 8'($urandom);
    st[1] = 1'b0;
    if ($urandom_range(0, 3) != 0) st[0] = 1'b1;
    push_req(uwf_pkg::KIND_WRITE, uwf_pkg::ADDR_STATUS, st, $urandom);
    tick_n(wait_cur + 1);
    a = ($urandom_range(0, 5) == 0) ? 2'($urandom) : uwf_pkg::ADDR_RX;
    push_req(uwf_pkg::KIND_READ, a, 8'($urandom), $urandom);
  endtask

  task automatic send_string();
    int n;
    tx_byte(8'(str_cur));
    n = $urandom_range(0, (wait_cur > 8) ? 1 : 5);
    repeat (n) tx_byte(8'($urandom_range(1, 255)));
    tx_byte(8'h00);
  endtask

  task automatic send_integer();
    logic [7:0] b;
    tx_byte(8'(int_cur));
    repeat (WORD_BYTES) begin
      b = 8'($urandom);
      case ($urandom_range(0, 5))
        0: b = 8'h00;
        1: b = 8'hFF;
        default: ;
      endcase
      tx_byte(b);
    end
  endtask

  task automatic send_bad_header();
    logic [7:0] b;
    do b = 8'($urandom); while (b == 8'(str_cur) || b == 8'(int_cur));
    tx_byte(b);
  endtask

  task automatic rx_word();
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: w = 32'h0000_0000;
      1: w = 32'hFFFF_FFFF;
      default: w = $urandom;
    endcase
    push_req(uwf_pkg::KIND_SUPPLY, 2'($urandom), 8'($urandom), w);
    repeat ($urandom_range(3, 5)) rx_byte();
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_cfg(input int w, input int s, input int i);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= uwf_pkg::CFG_WAIT_TICKS;
    cfg_wdata <= 8'(w);
    @(posedge clk);
    cfg_idx   <= uwf_pkg::CFG_STRING_CODE;
    cfg_wdata <= 8'(s);
    @(posedge clk);
    cfg_idx   <= uwf_pkg::CFG_INTEGER_CODE;
    cfg_wdata <= 8'(i);
    @(posedge clk);
    cfg_we   <= 1'b0;
    wait_cur = w;
    str_cur  = s;
    int_cur  = i;
  endtask

  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 9) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int   start;
    logic hold_done;
    hold_done            = 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= uwf_pkg::CFG_WAIT_TICKS;
    cfg_wdata            <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.kind          <= uwf_pkg::KIND_TICK;
    req_ch.reg_addr      <= uwf_pkg::ADDR_TX;
    req_ch.write_byte    <= '0;
    req_ch.supplied_word <= '0;
    wait_cur = uwf_pkg::WAIT_TICKS_RST;
    str_cur  = uwf_pkg::STRING_CODE_RST;
    int_cur  = uwf_pkg::INTEGER_CODE_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register reads at reset, unused address, receiver stalled with no word
    push_req(uwf_pkg::KIND_READ, uwf_pkg::ADDR_TX, 8'h00, 32'h0);
    push_req(uwf_pkg::KIND_READ, uwf_pkg::ADDR_RX, 8'h00, 32'h0);
    push_req(uwf_pkg::KIND_READ, uwf_pkg::ADDR_STATUS, 8'h00, 32'h0);
    push_req(uwf_pkg::KIND_READ, 2'd3, 8'h00, 32'h0);
    push_req(uwf_pkg::KIND_WRITE, 2'd3, 8'hFF, 32'hFFFF_FFFF);
    push_req(uwf_pkg::KIND_WRITE, uwf_pkg::ADDR_RX, 8'hA5, 32'h0);
    push_req(uwf_pkg::KIND_READ, uwf_pkg::ADDR_RX, 8'h00, 32'h0);
    push_req(uwf_pkg::KIND_WRITE, uwf_pkg::ADDR_STATUS, 8'hFD, 32'h0);
    tick_n(1);
    push_req(uwf_pkg::KIND_SUPPLY, uwf_pkg::ADDR_TX, 8'h00, 32'h80FF_0001);
    push_req(uwf_pkg::KIND_SUPPLY, uwf_pkg::ADDR_TX, 8'h00, 32'h1234_5678);
    tick_n(1);
    push_req(uwf_pkg::KIND_READ, uwf_pkg::ADDR_RX, 8'h00, 32'h0);
    // string with an all-ones character, invalid header, integer header
    tx_byte(8'h00);
    tx_byte(8'hFF);
    tx_byte(8'h00);
    tx_byte(8'h07);
    tx_byte(8'h04);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) apply_cfg(phase_wait[p], phase_str[p], phase_int[p]);
      start = item_count;
      while (item_count - start < phase_budget[p]) begin
        if ($urandom_range(0, 15) == 0) begin
          tx_idle_on = ($urandom_range(0, 2) != 0);
          rx_idle_on = ($urandom_range(0, 2) != 0);
        end
        if (!hold_done && item_count > 250) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        case ($urandom_range(0, 9))
          0, 1, 2, 3: send_string();
          4, 5:       send_integer();
          6:          send_bad_header();
          7, 8:       rx_word();
          default: begin
            repeat ($urandom_range(1, 4))
              push_req(uwf_pkg::kind_e'($urandom_range(0, 3)), 2'($urandom), 8'($urandom),
                       $urandom);
          end
        endcase
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/uwf_pkg.sv
rtl/uwf_if.sv
rtl/uwf_tx.sv
rtl/uart_word_framing_device_core.sv
rtl/uwf_checker.sv
tb/uwf_checker.sv
tb/testbench.sv
